@@ rtl/core/egc_pkg.sv @@
// shared types and constants of the echo-aware gate controller
package egc_pkg;

  localparam int FRAME_SAMPLES = 480;

  localparam logic [15:0] GATE_ONE        = 16'd32768;
  localparam logic [15:0] OPEN_LEVEL      = 16'd16384;
  localparam logic [15:0] REPLENISH_BELOW = 16'd9831;
  localparam logic [39:0] E_MAX           = 40'hFF_FFFF_FFFF;
  localparam logic [9:0]  COUNT_MAX       = 10'd1023;

  // register indexes of the configuration port
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_HANGOVER  = 3'd1;
  localparam logic [2:0] REG_RATIO_LO  = 3'd2;
  localparam logic [2:0] REG_RATIO_HI  = 3'd3;
  localparam logic [2:0] REG_ATTACK    = 3'd4;
  localparam logic [2:0] REG_DECAY     = 3'd5;
  localparam logic [2:0] REG_BUDGET    = 3'd6;
  localparam logic [2:0] REG_REPLENISH = 3'd7;

  typedef struct packed {
    logic [30:0] threshold;
    logic [7:0]  hangover_frames;
    logic [15:0] ratio_low;
    logic [15:0] ratio_high;
    logic [15:0] attack_coef;
    logic [15:0] decay_coef;
    logic [7:0]  budget_frames;
    logic [7:0]  replenish_step;
  } cfg_t;

  // one finished capture frame handed from front to back
  typedef struct packed {
    logic        window;
    logic [39:0] pre_energy;
    logic [39:0] post_energy;
  } frame_t;

  // square of a signed 16-bit sample
  function automatic logic [30:0] sq16(input logic signed [15:0] v);
    logic signed [31:0] p;
    p = v * v;
    return p[30:0];
  endfunction

  function automatic logic [39:0] sat_add(input logic [39:0] a, input logic [30:0] b);
    logic [40:0] s;
    s = {1'b0, a} + {10'd0, b};
    return s[40] ? E_MAX : s[39:0];
  endfunction

endpackage

@@ rtl/core/egc_front.sv @@
// front end: per-sample energy sums, render activity and hangover window
module egc_front (
  input  logic                clk,
  input  logic                rst,
  input  egc_pkg::cfg_t       cfg,
  input  logic                accept,
  input  logic                cmd,
  input  logic signed [15:0]  first_sample,
  input  logic signed [15:0]  second_sample,
  input  logic                frame_last,
  output logic                q_push,
  output egc_pkg::frame_t     q_data
);
  import egc_pkg::*;

  logic [39:0] render_energy, pre_energy, post_energy;
  logic [9:0]  render_count;
  logic [7:0]  hangover_left;

  logic [39:0] render_sum, pre_sum, post_sum, active_level;
  logic [9:0]  count_inc;
  logic        render_active;

  always_comb begin
    render_sum    = sat_add(render_energy, sq16(first_sample));
    pre_sum       = sat_add(pre_energy, sq16(first_sample));
    post_sum      = sat_add(post_energy, sq16(second_sample));
    count_inc     = (render_count < COUNT_MAX) ? render_count + 10'd1 : render_count;
    active_level  = {9'd0, cfg.threshold} * 40'(FRAME_SAMPLES);
    render_active = (count_inc == 10'(FRAME_SAMPLES)) && (render_sum > active_level);
  end

  assign q_push = accept && cmd && frame_last;
  assign q_data = '{window: (hangover_left != 8'd0), pre_energy: pre_sum,
                    post_energy: post_sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      render_energy <= '0;
      render_count  <= '0;
      pre_energy    <= '0;
      post_energy   <= '0;
      hangover_left <= '0;
    end else if (accept) begin
      if (!cmd) begin
        if (frame_last) begin
          if (render_active) hangover_left <= cfg.hangover_frames;
          render_energy <= '0;
          render_count  <= '0;
        end else begin
          render_energy <= render_sum;
          render_count  <= count_inc;
        end
      end else if (frame_last) begin
        pre_energy  <= '0;
        post_energy <= '0;
        if (hangover_left != 8'd0) hangover_left <= hangover_left - 8'd1;
      end else begin
        pre_energy  <= pre_sum;
        post_energy <= post_sum;
      end
    end
  end

endmodule

@@ rtl/core/egc_queue.sv @@
// two-entry frame queue between front and back
module egc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  egc_pkg::frame_t  wr_data,
  output logic             is_full,
  input  logic             rd,
  output egc_pkg::frame_t  rd_data,
  output logic             is_empty
);
  import egc_pkg::*;

  frame_t     slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign is_full  = (count == 2'd2);
  assign is_empty = (count == 2'd0);
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= wr_data;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/egc_back.sv @@
// back end: energy ratio, root, target mapping, budget and gate smoothing
module egc_back (
  input  logic             clk,
  input  logic             rst,
  input  egc_pkg::cfg_t    cfg,
  input  logic             q_empty,
  input  egc_pkg::frame_t  q_data,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [15:0]      gate,
  output logic             echo_window,
  output logic [7:0]       budget_left,
  output logic             forced_shut
);
  import egc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_ROOT, S_RAIL, S_SCALE, S_BUDGET, S_MUL, S_UPD, S_OUT
  } state_t;

  state_t      state;
  logic [39:0] pre;
  logic [40:0] rem;
  logic [31:0] quo;
  logic [4:0]  cnt;
  logic [15:0] root;
  logic [16:0] ratio;
  logic [16:0] srem;
  logic [15:0] den;
  logic [14:0] squo;
  logic [15:0] target;
  logic [15:0] smoothed_gate;
  logic [7:0]  budget_count;
  logic        window, forced;
  logic [31:0] prod;
  logic        rising;
  logic        out_valid;
  logic        out_load;

  logic [40:0] rem2;
  logic [15:0] trial;
  logic [31:0] trial_sq;
  logic [16:0] srem2;
  logic [8:0]  bud_sum;
  logic [7:0]  bud_a, bud_b;
  logic [15:0] k, d;
  logic [16:0] step;

  always_comb begin
    rem2     = {rem[39:0], 1'b0};
    trial    = root | (16'd1 << cnt[3:0]);
    trial_sq = trial * trial;
    srem2    = {srem[15:0], 1'b0};
    bud_sum  = {1'b0, budget_count} + {1'b0, cfg.replenish_step};
    if (target < REPLENISH_BELOW)
      bud_a = (bud_sum < {1'b0, cfg.budget_frames}) ? bud_sum[7:0] : cfg.budget_frames;
    else
      bud_a = budget_count;
    bud_b = (smoothed_gate > OPEN_LEVEL && bud_a != 8'd0) ? bud_a - 8'd1 : bud_a;
    k     = (target > smoothed_gate) ? cfg.attack_coef : cfg.decay_coef;
    d     = (target >= smoothed_gate) ? target - smoothed_gate : smoothed_gate - target;
    step  = 17'((33'(prod) + 33'd32768) >> 16);
  end

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign empty    = !out_valid;
  // result register takes a new frame when it is free or being popped
  assign out_load = (state == S_OUT) && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      smoothed_gate <= GATE_ONE;
      // default budget ceiling
      budget_count  <= 8'd60;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (pop && out_valid) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            window <= q_data.window;
            forced <= 1'b0;
            target <= GATE_ONE;
            pre    <= q_data.pre_energy;
            rem    <= {1'b0, q_data.post_energy};
            quo    <= '0;
            cnt    <= '0;
            if (!q_data.window) begin
              budget_count <= cfg.budget_frames;
              state        <= S_MUL;
            end else if (q_data.pre_energy == 40'd0) begin
              state <= S_BUDGET;
            end else if (q_data.post_energy >= q_data.pre_energy) begin
              ratio <= 17'd65536;
              state <= S_RAIL;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (rem2 >= {1'b0, pre}) begin
            rem <= rem2 - {1'b0, pre};
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= rem2;
            quo <= {quo[30:0], 1'b0};
          end
          if (cnt == 5'd31) begin
            root  <= '0;
            cnt   <= 5'd15;
            state <= S_ROOT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_ROOT: begin
          // cnt runs 15 down to 0 here (low four bits hold the bit position)
          if (trial_sq <= quo) root <= trial;
          cnt <= cnt - 5'd1;
          if (cnt[3:0] == 4'd0) state <= S_RAIL;
        end
        S_RAIL: begin
          if (cnt == 5'd31) ratio <= {1'b0, root};
          if (cnt == 5'd31) begin
            cnt <= '0;
          end else if (ratio <= {1'b0, cfg.ratio_low}) begin
            target <= '0;
            state  <= S_BUDGET;
          end else if (ratio >= {1'b0, cfg.ratio_high}) begin
            target <= GATE_ONE;
            state  <= S_BUDGET;
          end else begin
            srem  <= ratio - {1'b0, cfg.ratio_low};
            den   <= cfg.ratio_high - cfg.ratio_low;
            squo  <= '0;
            cnt   <= '0;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (srem2 >= {1'b0, den}) begin
            srem <= srem2 - {1'b0, den};
            squo <= {squo[13:0], 1'b1};
          end else begin
            srem <= srem2;
            squo <= {squo[13:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd14) state <= S_BUDGET;
        end
        S_BUDGET: begin
          if (cnt == 5'd15) target <= {1'b0, squo};
          if (cnt == 5'd15) begin
            cnt <= '0;
          end else begin
            budget_count <= bud_b;
            if (bud_b == 8'd0) begin
              target <= '0;
              forced <= 1'b1;
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod   <= k * d;
          rising <= (target >= smoothed_gate);
          state  <= S_UPD;
        end
        S_UPD: begin
          smoothed_gate <= rising ? smoothed_gate + step[15:0] : smoothed_gate - step[15:0];
          state         <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            gate        <= smoothed_gate;
            echo_window <= window;
            budget_left <= budget_count;
            forced_shut <= forced;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/echo_aware_gate_controller_core.sv @@
// top level of the echo-aware gate controller
// throughput: one sample transfer per cycle while the frame queue has room
// with the back end idle, a capture frame end outside the echo window goes straight
//   to the one-pole update, and inside it passes at most a 32-step energy divide,
//   16-step root, 15-step target scale, then budget and one-pole update
// the back end works one frame end at a time; two more frame ends may wait
// rst is synchronous and active high; it restores the register defaults
module echo_aware_gate_controller_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic               cmd,
  input  logic signed [15:0] first_sample,
  input  logic signed [15:0] second_sample,
  input  logic               frame_last,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        gate,
  output logic               echo_window,
  output logic [7:0]         budget_left,
  output logic               forced_shut
);
  import egc_pkg::*;

  cfg_t   cfg;
  logic   accept;
  logic   q_push, q_pop, q_full, q_empty;
  frame_t q_in, q_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold       <= 31'd10722;
      cfg.hangover_frames <= 8'd30;
      cfg.ratio_low       <= 16'd3277;
      cfg.ratio_high      <= 16'd16384;
      cfg.attack_coef     <= 16'd32768;
      cfg.decay_coef      <= 16'd19661;
      cfg.budget_frames   <= 8'd60;
      cfg.replenish_step  <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: cfg.threshold       <= cfg_data;
        REG_HANGOVER:  cfg.hangover_frames <= cfg_data[7:0];
        REG_RATIO_LO:  cfg.ratio_low       <= cfg_data[15:0];
        REG_RATIO_HI:  cfg.ratio_high      <= cfg_data[15:0];
        REG_ATTACK:    cfg.attack_coef     <= cfg_data[15:0];
        REG_DECAY:     cfg.decay_coef      <= cfg_data[15:0];
        REG_BUDGET:    cfg.budget_frames   <= cfg_data[7:0];
        REG_REPLENISH: cfg.replenish_step  <= cfg_data[7:0];
        default:       cfg.threshold       <= cfg.threshold;
      endcase
    end
  end

  // input transfers stall only when the frame queue is full
  assign full   = q_full;
  assign accept = push && !full;

  egc_front u_front (
    .clk, .rst, .cfg, .accept, .cmd, .first_sample, .second_sample, .frame_last,
    .q_push, .q_data(q_in)
  );

  egc_queue u_queue (
    .clk, .rst, .wr(q_push), .wr_data(q_in), .is_full(q_full),
    .rd(q_pop), .rd_data(q_out), .is_empty(q_empty)
  );

  // result register inside the back end decouples it from the consumer
  egc_back u_back (
    .clk, .rst, .cfg, .q_empty, .q_data(q_out), .q_pop,
    .pop, .empty, .gate, .echo_window, .budget_left, .forced_shut
  );

endmodule

@@ rtl/core/egc_checker.sv @@
// port-level checks of the gate controller and their binding
module egc_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [15:0] gate,
  input logic        echo_window,
  input logic [7:0]  budget_left,
  input logic        forced_shut
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(gate)))
    else $error("waiting result changed");

  a_gate_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (gate <= 16'd32768))
    else $error("gate above unity");

  a_forced_window: assert property (@(posedge clk) disable iff (rst)
    (!empty && forced_shut) |-> (echo_window && budget_left == 8'd0))
    else $error("forced shut without exhausted budget in window");

endmodule

bind echo_aware_gate_controller_core egc_checker u_egc_checker (
  .clk, .rst, .empty, .pop, .gate, .echo_window, .budget_left, .forced_shut
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the echo-aware gate controller core
module testbench;
  import egc_pkg::*;

  localparam bit CMD_RENDER  = 1'b0;
  localparam bit CMD_CAPTURE = 1'b1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [15:0] gate;
    logic        echo_window;
    logic [7:0]  budget_left;
    logic        forced_shut;
  } gate_result_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [30:0]        cfg_data;
  logic               push;
  logic               full;
  logic               cmd;
  logic signed [15:0] first_sample;
  logic signed [15:0] second_sample;
  logic               frame_last;
  logic               empty;
  logic               pop;
  logic [15:0]        gate;
  logic               echo_window;
  logic [7:0]         budget_left;
  logic               forced_shut;

  echo_aware_gate_controller_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full),
    .cmd(cmd), .first_sample(first_sample), .second_sample(second_sample),
    .frame_last(frame_last),
    .empty(empty), .pop(pop),
    .gate(gate), .echo_window(echo_window), .budget_left(budget_left),
    .forced_shut(forced_shut)
  );

  // register copy and gate state of the predictor
  longint unsigned regs [8];
  longint unsigned rnd_energy, rnd_count, cap_pre, cap_post;
  longint unsigned hang_left, gate_state, budget_state;

  gate_result_t pending_gates[$];
  int  mismatches;
  bit  send_burst;    // sender offers back to back
  bit  take_burst;    // receiver takes back to back
  bit  hold_go;
  bit  hold_on;
  int  cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous cycle limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("FAIL echo_aware_gate_controller_core");
        $finish;
      end
    end
  end

  function automatic longint unsigned square_of(logic signed [15:0] v);
    longint x;
    x = v;
    return longint'(x * x);
  endfunction

  function automatic longint unsigned add_sat40(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > 64'hFF_FFFF_FFFF) ? 64'hFF_FFFF_FFFF : s;
  endfunction

  // Q1.16 amplitude ratio sqrt(post/pre), saturating at one
  function automatic longint unsigned amp_ratio(longint unsigned post, longint unsigned pre);
    longint unsigned q, rem, r, t;
    q = 0;
    rem = post;
    r = 0;
    if (post >= pre) return 65536;
    for (int i = 0; i < 32; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= pre) begin
        rem = rem - pre;
        q = q | 1;
      end
    end
    for (int b = 15; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= q) r = t;
    end
    return r;
  endfunction

  function automatic void model_reset();
    regs[REG_THRESHOLD] = 10722;
    regs[REG_HANGOVER]  = 30;
    regs[REG_RATIO_LO]  = 3277;
    regs[REG_RATIO_HI]  = 16384;
    regs[REG_ATTACK]    = 32768;
    regs[REG_DECAY]     = 19661;
    regs[REG_BUDGET]    = 60;
    regs[REG_REPLENISH] = 2;
    rnd_energy = 0; rnd_count = 0; cap_pre = 0; cap_post = 0;
    hang_left = 0;
    gate_state = 32768;
    budget_state = 60;
  endfunction

  // advance the gate model by one accepted sample
  function automatic void gate_model_step(bit c, logic signed [15:0] a,
                                          logic signed [15:0] b, bit last);
    longint unsigned target, k, d, stp, r;
    bit win, forced;
    gate_result_t res;
    target = 32768;
    win = 0;
    forced = 0;
    if (c == CMD_RENDER) begin
      rnd_energy = add_sat40(rnd_energy, square_of(a));
      if (rnd_count < 1023) rnd_count++;
      if (last) begin
        if (rnd_count == FRAME_SAMPLES && rnd_energy > regs[REG_THRESHOLD] * FRAME_SAMPLES)
          hang_left = regs[REG_HANGOVER];
        rnd_energy = 0;
        rnd_count = 0;
      end
      return;
    end
    cap_pre = add_sat40(cap_pre, square_of(a));
    cap_post = add_sat40(cap_post, square_of(b));
    if (!last) return;
    if (hang_left > 0) begin
      win = 1;
      hang_left--;
      if (cap_pre != 0) begin
        r = amp_ratio(cap_post, cap_pre);
        if (r <= regs[REG_RATIO_LO]) target = 0;
        else if (r >= regs[REG_RATIO_HI]) target = 32768;
        else target = ((r - regs[REG_RATIO_LO]) * 32768) / (regs[REG_RATIO_HI] - regs[REG_RATIO_LO]);
      end
      // echo-dominated frame refills the budget up to the ceiling
      if (target < REPLENISH_BELOW) begin
        budget_state = budget_state + regs[REG_REPLENISH];
        if (budget_state > regs[REG_BUDGET]) budget_state = regs[REG_BUDGET];
      end
      if (gate_state > OPEN_LEVEL && budget_state > 0) budget_state--;
      if (budget_state == 0) begin
        target = 0;
        forced = 1;
      end
    end else begin
      budget_state = regs[REG_BUDGET];
    end
    cap_pre = 0;
    cap_post = 0;
    // asymmetric one-pole, rounded to nearest
    k = (target > gate_state) ? regs[REG_ATTACK] : regs[REG_DECAY];
    if (target >= gate_state) begin
      d = target - gate_state;
      stp = (k * d + 32768) >> 16;
      gate_state = gate_state + stp;
    end else begin
      d = gate_state - target;
      stp = (k * d + 32768) >> 16;
      gate_state = gate_state - stp;
    end
    res.gate = gate_state[15:0];
    res.echo_window = win;
    res.budget_left = budget_state[7:0];
    res.forced_shut = forced;
    pending_gates.push_back(res);
  endfunction

  // result checker and receiver stalls
  initial begin : result_check
    int stall;
    gate_result_t want;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (pending_gates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result gate=%0d", gate);
        end else begin
          want = pending_gates.pop_front();
          if (gate !== want.gate || echo_window !== want.echo_window ||
              budget_left !== want.budget_left || forced_shut !== want.forced_shut) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: gate %0d/%0d window %0b/%0b budget %0d/%0d shut %0b/%0b",
                       want.gate, gate, want.echo_window, echo_window,
                       want.budget_left, budget_left, want.forced_shut, forced_shut);
          end
        end
        stall = take_burst ? 0 : $urandom_range(0, 15);
      end else if (stall > 0) begin
        stall--;
      end
      pop <= (stall == 0) && !hold_on;
    end
  end

  // long receiver hold-off, counted here
  initial begin
    hold_on = 0;
    forever begin
      @(posedge clk iff hold_go);
      hold_on = 1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on = 0;
      hold_go = 0;
    end
  end

  // one sample transfer; push stays high when the next one follows at once
  task automatic send_sample(bit c, logic signed [15:0] a, logic signed [15:0] b, bit last);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    cmd <= c;
    first_sample <= a;
    second_sample <= b;
    frame_last <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    gate_model_step(c, a, b, last);
  endtask

  // sender pauses until every result is in and the back end is quiet
  task automatic wait_drained();
    push <= 1'b0;
    wait (pending_gates.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, longint unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[30:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_THRESHOLD: regs[idx] = val & 64'h7FFF_FFFF;
      REG_HANGOVER, REG_BUDGET, REG_REPLENISH: regs[idx] = val & 64'hFF;
      default: regs[idx] = val & 64'hFFFF;
    endcase
  endtask

  // render frame of len samples; shift sets the loudness, len off 480 drops it
  task automatic send_render_frame(int len, int shift);
    logic signed [15:0] s;
    for (int i = 0; i < len; i++) begin
      s = $signed(16'($urandom)) >>> shift;
      send_sample(CMD_RENDER, s, 16'($urandom), i == len - 1);
    end
  endtask

  // capture frame with a random relation between pre and post
  task automatic send_capture_frame(int len);
    logic signed [15:0] a, b;
    int kind;
    kind = $urandom_range(0, 5);
    for (int i = 0; i < len; i++) begin
      a = $signed(16'($urandom)) >>> $urandom_range(0, 3);
      case (kind)
        0: b = a >>> $urandom_range(0, 8);
        1: b = 16'($urandom);
        2: begin
          a = 0;
          b = 16'($urandom);
        end
        3: b = a >>> 1;
        default: b = $signed(16'($urandom)) >>> $urandom_range(0, 12);
      endcase
      send_sample(CMD_CAPTURE, a, b, i == len - 1);
    end
  endtask

  task automatic capture_frames(int n);
    for (int f = 0; f < n; f++) begin
      if ($urandom_range(0, 7) == 0) send_burst = ~send_burst;
      if ($urandom_range(0, 7) == 0) take_burst = ~take_burst;
      send_capture_frame($urandom_range(1, 3));
    end
  endtask

  // extremes, silent and misshaped frames with register defaults
  task automatic test_directed();
    send_sample(CMD_CAPTURE, -16'sd32768, 16'sd32767, 1'b1);
    send_sample(CMD_CAPTURE, 16'sd32767, -16'sd32768, 1'b1);
    send_sample(CMD_CAPTURE, 16'sd0, 16'sd0, 1'b1);
    send_sample(CMD_CAPTURE, -16'sd1, 16'sd1, 1'b0);
    send_sample(CMD_CAPTURE, 16'sd1, -16'sd1, 1'b1);
    // short render frame is dropped
    send_sample(CMD_RENDER, -16'sd32768, 16'sd0, 1'b0);
    send_sample(CMD_RENDER, 16'sd32767, -16'sd1, 1'b1);
    send_sample(CMD_CAPTURE, 16'sd100, 16'sd50, 1'b1);
    wait_drained();
  endtask

  // active render opens the default window, it runs out after hangover
  task automatic test_default_window();
    send_burst = 1;
    send_render_frame(FRAME_SAMPLES, $urandom_range(0, 4));
    capture_frames(35);
    wait_drained();
  endtask

  // extreme rails, fast smoothing, tiny budget without refill
  task automatic test_extreme_settings();
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_HANGOVER, 255);
    write_reg(REG_RATIO_LO, 0);
    write_reg(REG_RATIO_HI, 65535);
    write_reg(REG_ATTACK, 65535);
    write_reg(REG_DECAY, 0);
    write_reg(REG_BUDGET, 3);
    write_reg(REG_REPLENISH, 0);
    send_burst = 1;
    send_render_frame(FRAME_SAMPLES, 14);
    capture_frames(20);
    // silent captures inside the window
    send_sample(CMD_CAPTURE, 16'sd0, 16'sd7, 1'b1);
    send_sample(CMD_CAPTURE, 16'sd0, 16'sd0, 1'b1);
    wait_drained();
    // big refill, ceiling lowered below the running budget
    write_reg(REG_BUDGET, 255);
    write_reg(REG_REPLENISH, 255);
    write_reg(REG_ATTACK, 0);
    write_reg(REG_DECAY, 65535);
    capture_frames(10);
    wait_drained();
    write_reg(REG_BUDGET, 1);
    capture_frames(10);
    wait_drained();
  endtask

  // crossed rails, loud threshold and misshaped render frames
  task automatic test_reversed_rails();
    write_reg(REG_RATIO_LO, 40000);
    write_reg(REG_RATIO_HI, 1);
    write_reg(REG_BUDGET, 200);
    write_reg(REG_REPLENISH, 7);
    write_reg(REG_ATTACK, 20000);
    write_reg(REG_DECAY, 45000);
    capture_frames(20);
    wait_drained();
    write_reg(REG_RATIO_HI, 40000);
    capture_frames(10);
    wait_drained();
    // a threshold of 2^30 can never be exceeded
    write_reg(REG_THRESHOLD, 1073741824);
    write_reg(REG_HANGOVER, 0);
    send_burst = 1;
    send_render_frame(17, 0);
    capture_frames(8);
    wait_drained();
    write_reg(REG_THRESHOLD, 5000);
    write_reg(REG_HANGOVER, 12);
    send_burst = 1;
    send_render_frame(9, 0);
    capture_frames(5);
    wait_drained();
  endtask

  // receiver stops while sender keeps going, fills the frame queue
  task automatic test_backpressure();
    hold_go = 1;
    send_burst = 1;
    for (int i = 0; i < 40; i++) send_capture_frame(1);
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    push = 1'b0;
    cmd = 1'b0;
    first_sample = '0;
    second_sample = '0;
    frame_last = 1'b0;
    pop = 1'b0;
    mismatches = 0;
    send_burst = 0;
    take_burst = 0;
    hold_go = 0;
    model_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_default_window();
    test_extreme_settings();
    test_reversed_rails();
    test_backpressure();
    wait_drained();
    if (mismatches == 0 && pending_gates.size() == 0) begin
      $display("PASS echo_aware_gate_controller_core");
    end else begin
      $display("FAIL echo_aware_gate_controller_core");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/egc_pkg.sv
rtl/core/egc_front.sv
rtl/core/egc_queue.sv
rtl/core/egc_back.sv
rtl/core/echo_aware_gate_controller_core.sv
rtl/core/egc_checker.sv
tb/sv/testbench.sv
